// ----- design/mchtp_pkg.sv -----
// Shared types and constants for the modem capability hex TLV parser.
// No dependencies; used by every module of the block.
package mchtp_pkg;

   localparam logic [5:0] MAX_DECODED = 6'd50;
   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = RSP_PTR_W + 1;

   // string layout
   localparam logic [7:0] POS_VERSION = 8'd6;
   localparam logic [7:0] POS_MARKER  = 8'd9;
   localparam logic [7:0] POS_GAP     = 8'd12;
   localparam logic [7:0] POS_HEX     = 8'd14;
   localparam logic [7:0] POS_MAX     = 8'd255;

   // "docsis", first character in the low byte
   localparam logic [5:0][7:0] PREFIX_TEXT = 48'h73_69_73_63_6f_64;
   // ":05", first character in the low byte
   localparam logic [2:0][7:0] MARKER_TEXT = 24'h35_30_3a;

   localparam logic [7:0] CAP_TYPE_MIN  = 8'd1;
   localparam logic [7:0] CAP_TYPE_MAX  = 8'd12;
   localparam logic [7:0] CAP_TYPE_FILT = 8'd9;

   localparam logic KIND_CAP = 1'b0;
   localparam logic KIND_SUM = 1'b1;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]  char_position;
      logic        prefix_match;
      logic        marker_match;
      logic [23:0] version_chars;
      logic [3:0]  high_nibble;
      logic        nibble_pending;
      phase_type   tlv_phase;
      logic [7:0]  current_type;
      logic [7:0]  skip_remaining;
      logic [5:0]  decoded_count;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      char_position:  8'd0,
      prefix_match:   1'b1,
      marker_match:   1'b1,
      version_chars:  24'd0,
      high_nibble:    4'd0,
      nibble_pending: 1'b0,
      tlv_phase:      PH_TYPE,
      current_type:   8'd0,
      skip_remaining: 8'd0,
      decoded_count:  6'd0
   };

   typedef struct packed {
      logic       kind;
      logic       last_result;
      logic [7:0] version_c;
      logic [7:0] version_b;
      logic [7:0] version_a;
      logic       caps_present;
      logic       is_docsis;
      logic       filt_dot1q;
      logic       filt_dot1p;
      logic [7:0] cap_value;
      logic [3:0] cap_type;
   } result_type;

   // up to two results per character, first one in r0
   typedef struct packed {
      logic       one;
      logic       two;
      result_type r0;
      result_type r1;
   } push_type;

   typedef struct packed {
      logic [RSP_CNT_W-1:0] count;
   } queue_status_type;

   // hex digit value; '0'..'?' map straight, 'A'..'F' and 'a'..'f' to 10..15
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      case (c) inside
         [8'd48:8'd63]:  v = c[3:0];
         [8'd65:8'd70]:  v = c[3:0] + 4'd9;
         [8'd97:8'd102]: v = c[3:0] + 4'd9;
         default:        v = 4'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/modem_capability_hex_tlv_parser_core.sv -----
// Top level of the modem capability hex TLV parser.
// Instantiates mchtp_step and mchtp_rsp_fifo; uses mchtp_pkg.
//
// One character per cycle is taken on req_. The character is registered,
// decoded combinationally against the parse state, and its results (none, one,
// or two when the final character also completes a capability) are written
// into an 8-entry result queue; a result reaches rsp_ by way of the input
// register and the queue. The queue drains one result per cycle while
// rsp_tready is high; req_tready drops only while the queue cannot take two
// more results behind the character held in the input register, so the
// sustained rate is one character per cycle whenever rsp_tready stays high.
// A summary result ends every string and the parse state returns to reset
// after it. No startup pass is needed after reset.
module modem_capability_hex_tlv_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] cap_type, [11:4] cap_value, [12] filt_dot1p,
                                    // [13] filt_dot1q, [14] is_docsis, [15] caps_present,
                                    // [23:16] version_a, [31:24] version_b,
                                    // [39:32] version_c
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last_result
);

   localparam int unsigned CW = mchtp_pkg::RSP_CNT_W;

   mchtp_pkg::parse_state_type  state_ff, state_in;
   mchtp_pkg::push_type         push;
   mchtp_pkg::result_type       head;
   mchtp_pkg::queue_status_type qstat;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       req_accept;
   logic [CW-1:0] reserved;

   assign reserved   = qstat.count + (in_valid_ff ? CW'(2) : CW'(0));
   assign req_tready = (reserved <= CW'(mchtp_pkg::RSP_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign in_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= mchtp_pkg::STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (in_valid_ff) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   mchtp_step u_step (
      .cur       (state_ff),
      .ch        (in_ch_ff),
      .last_char (in_last_ff),
      .nxt       (state_in),
      .push      (push)
   );

   mchtp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (in_valid_ff),
      .push      (push),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (head),
      .status    (qstat)
   );

   assign rsp_tdata = {head.version_c, head.version_b, head.version_a,
                       head.caps_present, head.is_docsis, head.filt_dot1q,
                       head.filt_dot1p, head.cap_value, head.cap_type};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_result;

   // queue always has room for the item being decoded
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (qstat.count <= CW'(mchtp_pkg::RSP_DEPTH - 2)))
      else $error("result queue lacks room for a decoded item");

   // a summary always closes the results of its character
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == mchtp_pkg::KIND_SUM) |-> rsp_tlast)
      else $error("summary result without last flag");

   // a capability result carries a type in 1..12
   a_cap_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == mchtp_pkg::KIND_CAP)
      |-> (rsp_tdata[3:0] != 4'd0 && rsp_tdata[3:0] <= 4'd12))
      else $error("capability result with bad type");

   // end of string returns the parser to its reset state
   a_end_reset: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff) |=> (state_ff == mchtp_pkg::STATE_RESET))
      else $error("parse state not cleared after end of string");

endmodule

// ----- design/mchtp_step.sv -----
// Per-character update: prefix/version/marker checks, hex pairing, TLV walk.
// Pure combinational; uses mchtp_pkg.
module mchtp_step (
   input  mchtp_pkg::parse_state_type cur,
   input  logic [7:0]                 ch,
   input  logic                       last_char,
   output mchtp_pkg::parse_state_type nxt,
   output mchtp_pkg::push_type        push
);

   mchtp_pkg::parse_state_type mid;
   logic       have_byte;
   logic [7:0] byte_val;
   logic [3:0] nib;
   logic [1:0] vidx;
   logic [1:0] midx;
   logic       is_docsis;
   logic       caps_present;
   logic       cap_hit;
   logic [7:0] skip_dec;
   mchtp_pkg::result_type r_cap;
   mchtp_pkg::result_type r_sum;

   assign nib  = mchtp_pkg::nibble_of(ch);
   assign vidx = 2'(cur.char_position - mchtp_pkg::POS_VERSION);
   assign midx = 2'(cur.char_position - mchtp_pkg::POS_MARKER);

   // character decode and byte formation
   always_comb begin
      mid       = cur;
      have_byte = 1'b0;
      byte_val  = 8'd0;
      if (cur.char_position < mchtp_pkg::POS_VERSION) begin
         if (ch != mchtp_pkg::PREFIX_TEXT[cur.char_position[2:0]]) begin
            mid.prefix_match = 1'b0;
         end
      end else if (cur.char_position < mchtp_pkg::POS_MARKER) begin
         case (vidx)
            2'd0:    mid.version_chars[7:0]   = cur.version_chars[7:0] | ch;
            2'd1:    mid.version_chars[15:8]  = cur.version_chars[15:8] | ch;
            default: mid.version_chars[23:16] = cur.version_chars[23:16] | ch;
         endcase
      end else if (cur.char_position < mchtp_pkg::POS_GAP) begin
         if (ch != mchtp_pkg::MARKER_TEXT[midx]) begin
            mid.marker_match = 1'b0;
         end
      end else if (cur.char_position >= mchtp_pkg::POS_HEX && cur.prefix_match
                   && cur.marker_match && cur.decoded_count < mchtp_pkg::MAX_DECODED) begin
         if (!cur.nibble_pending) begin
            mid.high_nibble    = nib;
            mid.nibble_pending = 1'b1;
         end else begin
            byte_val           = {cur.high_nibble, nib};
            mid.nibble_pending = 1'b0;
            have_byte          = 1'b1;
         end
      end
      if (cur.char_position != mchtp_pkg::POS_MAX) begin
         mid.char_position = cur.char_position + 8'd1;
      end
      // odd digit count: lone digit padded with a zero low nibble
      if (last_char && mid.nibble_pending) begin
         byte_val           = {mid.high_nibble, 4'd0};
         mid.nibble_pending = 1'b0;
         have_byte          = 1'b1;
      end
      if (have_byte) begin
         mid.decoded_count = cur.decoded_count + 6'd1;
      end
   end

   assign skip_dec = (mid.skip_remaining != 8'd0) ? mid.skip_remaining - 8'd1
                                                   : mid.skip_remaining;

   // TLV walk next state
   always_comb begin
      nxt = mid;
      if (have_byte) begin
         unique case (mid.tlv_phase)
            mchtp_pkg::PH_TYPE: begin
               nxt.current_type = byte_val;
               nxt.tlv_phase    = mchtp_pkg::PH_LEN;
            end
            mchtp_pkg::PH_LEN: begin
               if (mid.current_type >= mchtp_pkg::CAP_TYPE_MIN
                   && mid.current_type <= mchtp_pkg::CAP_TYPE_MAX) begin
                  nxt.tlv_phase = mchtp_pkg::PH_VALUE;
               end else if (byte_val == 8'd0) begin
                  nxt.tlv_phase = mchtp_pkg::PH_TYPE;
               end else begin
                  nxt.skip_remaining = byte_val;
                  nxt.tlv_phase      = mchtp_pkg::PH_SKIP;
               end
            end
            mchtp_pkg::PH_VALUE: begin
               nxt.tlv_phase = mchtp_pkg::PH_TYPE;
            end
            mchtp_pkg::PH_SKIP: begin
               nxt.skip_remaining = skip_dec;
               if (skip_dec == 8'd0) nxt.tlv_phase = mchtp_pkg::PH_TYPE;
            end
            default: nxt.tlv_phase = mchtp_pkg::PH_TYPE;
         endcase
      end
      if (last_char) nxt = mchtp_pkg::STATE_RESET;
   end

   // results
   always_comb begin
      cap_hit      = have_byte && (mid.tlv_phase == mchtp_pkg::PH_VALUE);
      is_docsis    = mid.prefix_match && (mid.char_position >= mchtp_pkg::POS_VERSION);
      caps_present = mid.marker_match && (mid.char_position >= mchtp_pkg::POS_GAP);

      r_sum              = '0;
      r_sum.kind         = mchtp_pkg::KIND_SUM;
      r_sum.last_result  = 1'b1;
      r_sum.is_docsis    = is_docsis;
      r_sum.caps_present = caps_present;
      r_sum.version_a    = mid.version_chars[7:0];
      r_sum.version_b    = mid.version_chars[15:8];
      r_sum.version_c    = mid.version_chars[23:16];

      r_cap             = r_sum;
      r_cap.kind        = mchtp_pkg::KIND_CAP;
      r_cap.last_result = !last_char;
      r_cap.cap_type    = mid.current_type[3:0];
      r_cap.cap_value   = byte_val;
      r_cap.filt_dot1p  = (mid.current_type == mchtp_pkg::CAP_TYPE_FILT) && byte_val[0];
      r_cap.filt_dot1q  = (mid.current_type == mchtp_pkg::CAP_TYPE_FILT) && byte_val[1];

      push.one = cap_hit || last_char;
      push.two = cap_hit && last_char;
      push.r0  = cap_hit ? r_cap : r_sum;
      push.r1  = r_sum;
   end

endmodule

// ----- design/mchtp_rsp_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle while pop is high.
// Uses mchtp_pkg for the result and push types.
module mchtp_rsp_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_en,
   input  mchtp_pkg::push_type         push,
   input  logic                        pop,
   output logic                        out_valid,
   output mchtp_pkg::result_type       out_data,
   output mchtp_pkg::queue_status_type status
);

   localparam int unsigned PW = mchtp_pkg::RSP_PTR_W;
   localparam int unsigned CW = mchtp_pkg::RSP_CNT_W;

   mchtp_pkg::result_type entry_ff [mchtp_pkg::RSP_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          put_one;
   logic          put_two;
   logic          take;

   assign put_one = push_en && push.one;
   assign put_two = push_en && push.two;
   assign take    = pop && (count_ff != '0);

   always_comb begin
      wptr_in  = wptr_ff + PW'(put_one) + PW'(put_two);
      rptr_in  = rptr_ff + PW'(take);
      count_in = count_ff + CW'(put_one) + CW'(put_two) - CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put_one) entry_ff[wptr_ff] <= push.r0;
      if (put_two) entry_ff[PW'(wptr_ff + PW'(1))] <= push.r1;
   end

   assign out_valid    = (count_ff != '0);
   assign out_data     = entry_ff[rptr_ff];
   assign status.count = count_ff;

endmodule
